### hdl/mrtu_pkg.sv
`default_nettype none
package mrtu_pkg;

   localparam int IMAGE_WORDS = 64;
   localparam int FRAME_BYTES = 256;

   localparam int IMG_AW  = $clog2(IMAGE_WORDS);
   localparam int BIT_AW  = IMG_AW + 4;
   localparam int MEM_AW  = IMG_AW + 2;
   localparam int MEM_WORDS = 4 * IMAGE_WORDS;
   localparam int FR_AW   = $clog2(FRAME_BYTES);
   localparam int CNT_W   = FR_AW + 1;
   localparam int SUM_W   = (BIT_AW > 12) ? BIT_AW : 12;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 72;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0]  COIL_ON  = 8'hFF;

   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_DIAG          = 8'd8;
   localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

   localparam logic [1:0] TBL_COIL     = 2'd0;
   localparam logic [1:0] TBL_DISCRETE = 2'd1;
   localparam logic [1:0] TBL_HOLDING  = 2'd2;
   localparam logic [1:0] TBL_INPUT    = 2'd3;

   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_LENGTH    = 3'd1;
   localparam logic [2:0] STS_CRC       = 3'd2;
   localparam logic [2:0] STS_INVALID   = 3'd3;
   localparam logic [2:0] STS_EXCEPTION = 3'd4;

   localparam logic [1:0] CSR_SLAVE    = 2'd0;
   localparam logic [1:0] CSR_FUNCTION = 2'd1;
   localparam logic [1:0] CSR_START    = 2'd2;
   localparam logic [1:0] CSR_QUANTITY = 2'd3;

   typedef enum logic [1:0] {
      KIND_TX_PULL   = 2'd0,
      KIND_RX_BYTE   = 2'd1,
      KIND_IMG_WRITE = 2'd2,
      KIND_IMG_READ  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_TX_RD1, ST_TX_FIN, ST_CRC_RD, ST_CRC_ACC,
      ST_HDR_RD, ST_HDR_CAP, ST_CHECK, ST_UB_RD, ST_UB_WR, ST_UW_RD0,
      ST_UW_RD1, ST_UW_WR, ST_FINISH
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LATCH, OP_DISPATCH, OP_TX_RD1, OP_TX_FIN, OP_CRC_RD,
      OP_CRC_ACC, OP_HDR_RD, OP_HDR_CAP, OP_CHECK, OP_UB_RD, OP_UB_WR,
      OP_UW_RD0, OP_UW_RD1, OP_UW_WR, OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
      logic     n_bad;
      logic     crc_last;
      logic     hdr_last;
      logic     unpack_bits;
      logic     unpack_words;
      logic     loop_last;
      logic     out_free;
   } dp_sts_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // request length without crc, zero when oversize
   function automatic logic [9:0] req_len(input logic [7:0] fc, input logic [10:0] qty);
      logic [11:0] c15;
      logic [11:0] c16;
      logic [11:0] len;
      logic        ovf;
      c15 = (12'(qty) + 12'd7) >> 3;
      c16 = {qty, 1'b0};
      ovf = 1'b0;
      case (fc)
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
         FC_WRITE_COIL, FC_WRITE_REG: len = 12'd6;
         FC_DIAG: len = 12'd4;
         FC_WRITE_COILS: begin
            ovf = (c15 > 12'd255);
            len = 12'd7 + c15;
         end
         FC_WRITE_REGS: begin
            ovf = (c16 > 12'd255);
            len = 12'd7 + c16;
         end
         default: len = 12'd2;
      endcase
      if (len + 12'd2 > 12'(FRAME_BYTES)) ovf = 1'b1;
      return ovf ? 10'd0 : len[9:0];
   endfunction

endpackage
`default_nettype wire

### hdl/mrtu_ctrl.sv
`default_nettype none
module mrtu_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     idle,
   output mrtu_pkg::dp_cmd_type     cmd,
   input  wire mrtu_pkg::dp_sts_type sts
);
   import mrtu_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (sts.kind)
               KIND_TX_PULL: state_in = ST_TX_RD1;
               KIND_RX_BYTE: state_in = (sts.last && !sts.n_bad) ? ST_CRC_RD : ST_FINISH;
               default:      state_in = ST_FINISH;
            endcase
         end
         ST_TX_RD1:   state_in = ST_TX_FIN;
         ST_TX_FIN:   if (sts.out_free) state_in = ST_IDLE;
         ST_CRC_RD:   state_in = ST_CRC_ACC;
         ST_CRC_ACC:  state_in = sts.crc_last ? ST_HDR_RD : ST_CRC_RD;
         ST_HDR_RD:   state_in = ST_HDR_CAP;
         ST_HDR_CAP:  state_in = sts.hdr_last ? ST_CHECK : ST_HDR_RD;
         ST_CHECK: begin
            if (sts.unpack_bits) state_in = ST_UB_RD;
            else if (sts.unpack_words) state_in = ST_UW_RD0;
            else state_in = ST_FINISH;
         end
         ST_UB_RD:    state_in = ST_UB_WR;
         ST_UB_WR:    state_in = sts.loop_last ? ST_FINISH : ST_UB_RD;
         ST_UW_RD0:   state_in = ST_UW_RD1;
         ST_UW_RD1:   state_in = ST_UW_WR;
         ST_UW_WR:    state_in = sts.loop_last ? ST_FINISH : ST_UW_RD0;
         ST_FINISH:   if (sts.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      idle   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (req_valid) cmd.op = OP_LATCH;
         end
         ST_DISPATCH: cmd.op = OP_DISPATCH;
         ST_TX_RD1:   cmd.op = OP_TX_RD1;
         ST_TX_FIN:   if (sts.out_free) cmd.op = OP_TX_FIN;
         ST_CRC_RD:   cmd.op = OP_CRC_RD;
         ST_CRC_ACC:  cmd.op = OP_CRC_ACC;
         ST_HDR_RD:   cmd.op = OP_HDR_RD;
         ST_HDR_CAP:  cmd.op = OP_HDR_CAP;
         ST_CHECK:    cmd.op = OP_CHECK;
         ST_UB_RD:    cmd.op = OP_UB_RD;
         ST_UB_WR:    cmd.op = OP_UB_WR;
         ST_UW_RD0:   cmd.op = OP_UW_RD0;
         ST_UW_RD1:   cmd.op = OP_UW_RD1;
         ST_UW_WR:    cmd.op = OP_UW_WR;
         ST_FINISH:   if (sts.out_free) cmd.op = OP_FINISH;
         default:     cmd.op = OP_NONE;
      endcase
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_DISPATCH)
      else $error("accepted item not dispatched");

   a_crc_pairs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRC_ACC) |-> $past(state_ff) == ST_CRC_RD)
      else $error("crc accumulate without a buffer read");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_TX_FIN || cmd.op == OP_FINISH) |-> sts.out_free)
      else $error("result loaded over an untaken result");

endmodule
`default_nettype wire

### hdl/mrtu_dp.sv
`default_nettype none
module mrtu_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mrtu_pkg::dp_cmd_type cmd,
   output mrtu_pkg::dp_sts_type     sts,
   input  wire logic [1:0]          in_kind,
   input  wire logic [7:0]          in_rx_data,
   input  wire logic                in_rx_last,
   input  wire logic [1:0]          in_table_select,
   input  wire logic [5:0]          in_table_index,
   input  wire logic [15:0]         in_table_word,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_idx,
   input  wire logic [10:0]         csr_wdata,
   input  wire logic                out_ready,
   output logic                     out_valid,
   output logic [7:0]               out_tx_byte,
   output logic                     out_tx_last,
   output logic                     out_response_done,
   output logic [2:0]               out_status,
   output logic [7:0]               out_exception_code,
   output logic [15:0]              out_error_total,
   output logic [7:0]               out_error_slave,
   output logic [7:0]               out_error_function,
   output logic [15:0]              out_read_word
);
   import mrtu_pkg::*;

   // configuration
   logic [7:0]  slave_ff, slave_in, func_ff, func_in;
   logic [9:0]  start_ff, start_in;
   logic [10:0] qty_ff, qty_in;
   // request side
   logic [8:0]  pos_ff, pos_in;
   logic [15:0] tx_crc_ff, tx_crc_in;
   logic [15:0] w0_ff, w0_in;
   // latched item
   kind_type    kind_ff, kind_in;
   logic [7:0]  rxd_ff, rxd_in;
   logic        last_ff, last_in;
   logic [1:0]  sel_ff, sel_in;
   logic [5:0]  idx_ff, idx_in;
   logic [15:0] word_ff, word_in;
   // response side
   logic [CNT_W-1:0] rx_count_ff, rx_count_in, ev_n_ff, ev_n_in, ptr_ff, ptr_in;
   logic [15:0] ev_crc_ff, ev_crc_in;
   logic [2:0]  hstep_ff, hstep_in;
   logic [7:0]  hdr_ff [5];
   logic [7:0]  hdr_in [5];
   logic [2:0]  ev_status_ff, ev_status_in;
   logic [7:0]  ev_exc_ff, ev_exc_in;
   logic [10:0] loop_ff, loop_in;
   logic [7:0]  hi_ff, hi_in;
   // error log
   logic [15:0] err_total_ff, err_total_in;
   logic [7:0]  err_slave_ff, err_slave_in, err_func_ff, err_func_in;
   // result register
   logic        o_valid_ff, o_valid_in, o_last_ff, o_last_in, o_done_ff, o_done_in;
   logic [7:0]  o_byte_ff, o_byte_in, o_exc_ff, o_exc_in;
   logic [2:0]  o_status_ff, o_status_in;
   logic [15:0] o_total_ff, o_total_in, o_read_ff, o_read_in;
   logic [7:0]  o_slave_ff, o_slave_in, o_func_ff, o_func_in;

   // image and frame stores
   logic [15:0]          img_mem [MEM_WORDS];
   logic [MEM_WORDS-1:0] img_valid_ff;
   logic [15:0]          img_q_ff;
   logic                 img_vq_ff;
   logic [7:0]           fr_mem [FRAME_BYTES];
   logic [7:0]           fr_q_ff;

   logic              img_rd, img_wr, fr_rd, fr_wr;
   logic [MEM_AW-1:0] img_raddr, img_waddr;
   logic [15:0]       img_wdata;
   logic [FR_AW-1:0]  fr_raddr, fr_waddr;

   // request byte build
   logic [15:0]       img_word;
   logic [9:0]        tx_len;
   logic [SUM_W-1:0]  start_ext, tx_k15, b15, w16, bitn;
   logic [IMG_AW-1:0] w15_0, w15_1;
   logic [11:0]       c15, c16, rem15, need;
   logic [31:0]       pair;
   logic [7:0]        pack15, mask15, req_byte;
   logic [CNT_W-1:0]  n_new, n_m2, n_m3;
   logic              n_bad, rd_func;
   logic [1:0]        func_tbl;
   logic [2:0]        chk_status;
   logic [7:0]        chk_exc;
   logic [15:0]       ub_word;
   logic              err_hit, load_out;
   logic [7:0]        r_byte;
   logic              r_last, r_done;
   logic [2:0]        r_status;
   logic [7:0]        r_exc;
   logic [15:0]       r_read;

   assign img_word  = img_vq_ff ? img_q_ff : 16'h0000;
   assign tx_len    = req_len(func_ff, qty_ff);
   assign start_ext = SUM_W'(start_ff);
   assign tx_k15    = SUM_W'(pos_ff) - SUM_W'(7);
   assign b15       = start_ext + (tx_k15 << 3);
   assign w16       = start_ext + (tx_k15 >> 1);
   assign w15_0     = b15[BIT_AW-1:4];
   assign w15_1     = w15_0 + IMG_AW'(1);
   assign c15       = (12'(qty_ff) + 12'd7) >> 3;
   assign c16       = {qty_ff, 1'b0};
   assign pair      = {img_word, w0_ff} >> b15[3:0];
   assign rem15     = 12'(qty_ff) - 12'(tx_k15 << 3);
   assign mask15    = (rem15 >= 12'd8) ? 8'hFF : ~(8'hFF << rem15[2:0]);
   assign pack15    = pair[7:0] & mask15;
   assign bitn      = start_ext + SUM_W'(loop_ff);
   assign func_tbl  = 2'(func_ff[1:0] - 2'd1);
   assign rd_func   = (func_ff == FC_READ_COILS) || (func_ff == FC_READ_DISCRETE) ||
                      (func_ff == FC_READ_HOLDING) || (func_ff == FC_READ_INPUT);
   assign need      = ((func_ff == FC_READ_COILS) || (func_ff == FC_READ_DISCRETE)) ? c15 : c16;
   assign n_new     = (rx_count_ff <= CNT_W'(FRAME_BYTES)) ? rx_count_ff + CNT_W'(1)
                                                          : rx_count_ff;
   assign n_bad     = (n_new < CNT_W'(5)) || (n_new > CNT_W'(FRAME_BYTES));
   assign n_m2      = ev_n_ff - CNT_W'(2);
   assign n_m3      = ev_n_ff - CNT_W'(3);

   always_comb begin
      if (pos_ff == 9'd0) req_byte = slave_ff;
      else if (pos_ff == 9'd1) req_byte = func_ff;
      else if (func_ff == FC_DIAG) req_byte = 8'h00;
      else if (pos_ff == 9'd2) req_byte = {6'd0, start_ff[9:8]};
      else if (pos_ff == 9'd3) req_byte = start_ff[7:0];
      else if (func_ff == FC_WRITE_COIL)
         req_byte = (pos_ff == 9'd4 && w0_ff[start_ext[3:0]]) ? COIL_ON : 8'h00;
      else if (func_ff == FC_WRITE_REG)
         req_byte = (pos_ff == 9'd4) ? w0_ff[15:8] : w0_ff[7:0];
      else if (pos_ff == 9'd4) req_byte = {5'd0, qty_ff[10:8]};
      else if (pos_ff == 9'd5) req_byte = qty_ff[7:0];
      else if (func_ff == FC_WRITE_COILS)
         req_byte = (pos_ff == 9'd6) ? c15[7:0] : pack15;
      else if (pos_ff == 9'd6) req_byte = c16[7:0];
      else req_byte = tx_k15[0] ? w0_ff[7:0] : w0_ff[15:8];
   end

   // frame checks once crc and header bytes are in
   always_comb begin
      chk_exc = 8'h00;
      if ({hdr_ff[1], hdr_ff[0]} != ev_crc_ff) chk_status = STS_CRC;
      else if (hdr_ff[2] != slave_ff || hdr_ff[3] != func_ff) begin
         if (hdr_ff[3][7]) begin
            chk_status = STS_EXCEPTION;
            chk_exc    = hdr_ff[4];
         end else begin
            chk_status = STS_INVALID;
         end
      end else if (!rd_func) chk_status = STS_OK;
      else if (12'(hdr_ff[4]) != 12'(ev_n_ff - CNT_W'(5)) || 12'(hdr_ff[4]) != need)
         chk_status = STS_LENGTH;
      else chk_status = STS_OK;
   end

   always_comb begin
      ub_word = img_word;
      ub_word[bitn[3:0]] = fr_q_ff[loop_ff[2:0]];
   end

   always_comb begin
      slave_in = slave_ff;  func_in = func_ff;  start_in = start_ff;  qty_in = qty_ff;
      pos_in = pos_ff;  tx_crc_in = tx_crc_ff;  w0_in = w0_ff;
      kind_in = kind_ff;  rxd_in = rxd_ff;  last_in = last_ff;
      sel_in = sel_ff;  idx_in = idx_ff;  word_in = word_ff;
      rx_count_in = rx_count_ff;  ev_n_in = ev_n_ff;  ptr_in = ptr_ff;
      ev_crc_in = ev_crc_ff;  hstep_in = hstep_ff;  hdr_in = hdr_ff;
      ev_status_in = ev_status_ff;  ev_exc_in = ev_exc_ff;
      loop_in = loop_ff;  hi_in = hi_ff;
      err_total_in = err_total_ff;  err_slave_in = err_slave_ff;  err_func_in = err_func_ff;
      img_rd = 1'b0;  img_raddr = '0;  img_wr = 1'b0;  img_waddr = '0;  img_wdata = '0;
      fr_rd = 1'b0;  fr_raddr = '0;  fr_wr = 1'b0;  fr_waddr = '0;
      err_hit = 1'b0;  load_out = 1'b0;
      r_byte = 8'h00;  r_last = 1'b0;  r_done = 1'b0;  r_status = STS_OK;
      r_exc = 8'h00;  r_read = 16'h0000;

      if (csr_we) begin
         case (csr_idx)
            CSR_SLAVE:    slave_in = csr_wdata[7:0];
            CSR_FUNCTION: func_in  = csr_wdata[7:0];
            CSR_START:    start_in = csr_wdata[9:0];
            CSR_QUANTITY: qty_in   = csr_wdata;
            default:      ;
         endcase
         pos_in    = 9'd0;
         tx_crc_in = CRC_INIT;
      end

      case (cmd.op)
         OP_LATCH: begin
            kind_in = kind_type'(in_kind);
            rxd_in  = in_rx_data;
            last_in = in_rx_last;
            sel_in  = in_table_select;
            idx_in  = in_table_index;
            word_in = in_table_word;
         end
         OP_DISPATCH: begin
            case (kind_ff)
               KIND_TX_PULL: begin
                  img_rd = 1'b1;
                  case (func_ff)
                     FC_WRITE_COIL:  img_raddr = {TBL_COIL, start_ext[BIT_AW-1:4]};
                     FC_WRITE_REG:   img_raddr = {TBL_HOLDING, start_ext[IMG_AW-1:0]};
                     FC_WRITE_COILS: img_raddr = {TBL_COIL, w15_0};
                     default:        img_raddr = {TBL_HOLDING, w16[IMG_AW-1:0]};
                  endcase
               end
               KIND_RX_BYTE: begin
                  fr_wr        = (rx_count_ff < CNT_W'(FRAME_BYTES));
                  fr_waddr     = rx_count_ff[FR_AW-1:0];
                  rx_count_in  = last_ff ? '0 : n_new;
                  ev_n_in      = n_new;
                  ev_status_in = n_bad ? STS_LENGTH : STS_OK;
                  ev_exc_in    = 8'h00;
                  ev_crc_in    = CRC_INIT;
                  ptr_in       = '0;
                  hstep_in     = 3'd0;
               end
               KIND_IMG_WRITE: begin
                  img_wr    = 1'b1;
                  img_waddr = {sel_ff, idx_ff[IMG_AW-1:0]};
                  img_wdata = word_ff;
               end
               default: begin
                  img_rd    = 1'b1;
                  img_raddr = {sel_ff, idx_ff[IMG_AW-1:0]};
               end
            endcase
         end
         OP_TX_RD1: begin
            w0_in     = img_word;
            img_rd    = 1'b1;
            img_raddr = {TBL_COIL, w15_1};
         end
         OP_TX_FIN: begin
            load_out = 1'b1;
            if (tx_len == 10'd0) begin
               r_last    = 1'b1;
               r_status  = STS_LENGTH;
               err_hit   = 1'b1;
               pos_in    = 9'd0;
               tx_crc_in = CRC_INIT;
            end else if ({1'b0, pos_ff} < tx_len) begin
               r_byte    = req_byte;
               tx_crc_in = crc_byte(tx_crc_ff, req_byte);
               pos_in    = pos_ff + 9'd1;
            end else if ({1'b0, pos_ff} == tx_len) begin
               r_byte = tx_crc_ff[7:0];
               pos_in = pos_ff + 9'd1;
            end else begin
               r_byte    = tx_crc_ff[15:8];
               r_last    = 1'b1;
               pos_in    = 9'd0;
               tx_crc_in = CRC_INIT;
            end
         end
         OP_CRC_RD: begin
            fr_rd    = 1'b1;
            fr_raddr = ptr_ff[FR_AW-1:0];
         end
         OP_CRC_ACC: begin
            ev_crc_in = crc_byte(ev_crc_ff, fr_q_ff);
            ptr_in    = ptr_ff + CNT_W'(1);
         end
         OP_HDR_RD: begin
            fr_rd = 1'b1;
            case (hstep_ff)
               3'd0:    fr_raddr = n_m2[FR_AW-1:0];
               3'd1:    fr_raddr = FR_AW'(n_m2 + CNT_W'(1));
               3'd2:    fr_raddr = FR_AW'(0);
               3'd3:    fr_raddr = FR_AW'(1);
               default: fr_raddr = FR_AW'(2);
            endcase
         end
         OP_HDR_CAP: begin
            hdr_in[hstep_ff] = fr_q_ff;
            hstep_in = hstep_ff + 3'd1;
         end
         OP_CHECK: begin
            ev_status_in = chk_status;
            ev_exc_in    = chk_exc;
            loop_in      = 11'd0;
         end
         OP_UB_RD: begin
            fr_rd     = 1'b1;
            fr_raddr  = FR_AW'(12'd3 + 12'(loop_ff >> 3));
            img_rd    = 1'b1;
            img_raddr = {func_tbl, bitn[BIT_AW-1:4]};
         end
         OP_UB_WR: begin
            img_wr    = 1'b1;
            img_waddr = {func_tbl, bitn[BIT_AW-1:4]};
            img_wdata = ub_word;
            loop_in   = loop_ff + 11'd1;
         end
         OP_UW_RD0: begin
            fr_rd    = 1'b1;
            fr_raddr = FR_AW'({loop_ff, 1'b0} + 12'd3);
         end
         OP_UW_RD1: begin
            hi_in    = fr_q_ff;
            fr_rd    = 1'b1;
            fr_raddr = FR_AW'({loop_ff, 1'b0} + 12'd4);
         end
         OP_UW_WR: begin
            img_wr    = 1'b1;
            img_waddr = {func_tbl, bitn[IMG_AW-1:0]};
            img_wdata = {hi_ff, fr_q_ff};
            loop_in   = loop_ff + 11'd1;
         end
         OP_FINISH: begin
            load_out = 1'b1;
            r_done   = (kind_ff == KIND_RX_BYTE) && last_ff;
            r_status = r_done ? ev_status_ff : STS_OK;
            r_exc    = (r_done && ev_status_ff == STS_EXCEPTION) ? ev_exc_ff : 8'h00;
            r_read   = (kind_ff == KIND_IMG_READ) ? img_word : 16'h0000;
            err_hit  = (r_status != STS_OK);
         end
         default: ;
      endcase

      if (err_hit) begin
         err_total_in = err_total_ff + 16'd1;
         err_slave_in = slave_ff;
         err_func_in  = func_ff;
      end
   end

   always_comb begin
      o_valid_in = o_valid_ff;
      o_byte_in = o_byte_ff;  o_last_in = o_last_ff;  o_done_in = o_done_ff;
      o_status_in = o_status_ff;  o_exc_in = o_exc_ff;  o_total_in = o_total_ff;
      o_slave_in = o_slave_ff;  o_func_in = o_func_ff;  o_read_in = o_read_ff;
      if (load_out) begin
         o_valid_in  = 1'b1;
         o_byte_in   = r_byte;
         o_last_in   = r_last;
         o_done_in   = r_done;
         o_status_in = r_status;
         o_exc_in    = r_exc;
         o_total_in  = err_total_in;
         o_slave_in  = err_slave_in;
         o_func_in   = err_func_in;
         o_read_in   = r_read;
      end else if (out_ready) begin
         o_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff     <= 8'd1;
         func_ff      <= FC_READ_HOLDING;
         start_ff     <= 10'd0;
         qty_ff       <= 11'd1;
         pos_ff       <= 9'd0;
         tx_crc_ff    <= CRC_INIT;
         rx_count_ff  <= '0;
         err_total_ff <= 16'd0;
         err_slave_ff <= 8'd0;
         err_func_ff  <= 8'd0;
         o_valid_ff   <= 1'b0;
         img_valid_ff <= '0;
      end else begin
         slave_ff     <= slave_in;
         func_ff      <= func_in;
         start_ff     <= start_in;
         qty_ff       <= qty_in;
         pos_ff       <= pos_in;
         tx_crc_ff    <= tx_crc_in;
         rx_count_ff  <= rx_count_in;
         err_total_ff <= err_total_in;
         err_slave_ff <= err_slave_in;
         err_func_ff  <= err_func_in;
         o_valid_ff   <= o_valid_in;
         if (img_wr) img_valid_ff[img_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      w0_ff <= w0_in;  kind_ff <= kind_in;  rxd_ff <= rxd_in;  last_ff <= last_in;
      sel_ff <= sel_in;  idx_ff <= idx_in;  word_ff <= word_in;
      ev_n_ff <= ev_n_in;  ptr_ff <= ptr_in;  ev_crc_ff <= ev_crc_in;
      hstep_ff <= hstep_in;  hdr_ff <= hdr_in;
      ev_status_ff <= ev_status_in;  ev_exc_ff <= ev_exc_in;
      loop_ff <= loop_in;  hi_ff <= hi_in;
      o_byte_ff <= o_byte_in;  o_last_ff <= o_last_in;  o_done_ff <= o_done_in;
      o_status_ff <= o_status_in;  o_exc_ff <= o_exc_in;  o_total_ff <= o_total_in;
      o_slave_ff <= o_slave_in;  o_func_ff <= o_func_in;  o_read_ff <= o_read_in;
   end

   always_ff @(posedge clock) begin
      if (img_wr) img_mem[img_waddr] <= img_wdata;
      if (img_rd) begin
         img_q_ff  <= img_mem[img_raddr];
         img_vq_ff <= img_valid_ff[img_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (fr_wr) fr_mem[fr_waddr] <= rxd_ff;
      if (fr_rd) fr_q_ff <= fr_mem[fr_raddr];
   end

   assign sts.kind         = kind_ff;
   assign sts.last         = last_ff;
   assign sts.n_bad        = n_bad;
   assign sts.crc_last     = (ptr_ff == n_m3);
   assign sts.hdr_last     = (hstep_ff == 3'd4);
   assign sts.unpack_bits  = (chk_status == STS_OK) && (qty_ff != 11'd0) &&
                             ((func_ff == FC_READ_COILS) || (func_ff == FC_READ_DISCRETE));
   assign sts.unpack_words = (chk_status == STS_OK) && (qty_ff != 11'd0) &&
                             ((func_ff == FC_READ_HOLDING) || (func_ff == FC_READ_INPUT));
   assign sts.loop_last    = (loop_ff == qty_ff - 11'd1);
   assign sts.out_free     = !o_valid_ff || out_ready;

   assign out_valid          = o_valid_ff;
   assign out_tx_byte        = o_byte_ff;
   assign out_tx_last        = o_last_ff;
   assign out_response_done  = o_done_ff;
   assign out_status         = o_status_ff;
   assign out_exception_code = o_exc_ff;
   assign out_error_total    = o_total_ff;
   assign out_error_slave    = o_slave_ff;
   assign out_error_function = o_func_ff;
   assign out_read_word      = o_read_ff;

endmodule
`default_nettype wire

### hdl/modbus_rtu_master_frame_engine_core.sv
`default_nettype none
// modbus rtu master frame engine. holds coil, discrete input, holding and input
// register images of one slave (64 words each) that the host reads and writes
// through image transfers, hands out request frame bytes one per pull transfer
// with crc-16 appended low byte first, and buffers response bytes; the transfer
// that carries the last response byte checks length, crc, address, function and
// byte count, unpacks read data into the images and updates the error log.
// every transfer yields exactly one result transfer. a request byte pull makes
// two image reads that feed the coil packing. the last response byte of a frame
// runs the crc over the bytes before the crc, reads the crc and header bytes,
// then unpacks each coil for functions 1 and 2 or each register for functions
// 3 and 4; the frame buffer is read one byte per access. images reset to zero
// through per-word valid flags, so there is no clearing pass after reset. a
// finished result waits in an output register; while it is not taken the next
// item is still accepted and processed, but its result then stalls the
// sequencer, which holds off further request and register transfers until the
// output register frees up.
module modbus_rtu_master_frame_engine_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request item transfer
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // rx_data, table_select, table_index, table_word
   input  wire logic        req_tlast,   // rx_last
   input  wire logic [1:0]  req_tuser,   // kind
   // result transfer
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // tx_byte, status, exception_code, error_total,
                                         // error_slave, error_function, read_word, zero pad
   output logic             rsp_tlast,   // tx_last
   output logic [0:0]       rsp_tuser,   // response_done
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_data
);
   import mrtu_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       idle;

   logic [7:0]  o_tx_byte, o_exc, o_slave, o_func;
   logic        o_tx_last, o_done;
   logic [2:0]  o_status;
   logic [15:0] o_total, o_read;

   // items accepted only while the sequencer is idle
   assign req_tready = idle;
   // register writes only land between items
   assign csr_ready  = idle;

   mrtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .idle      (idle),
      .cmd       (cmd),
      .sts       (sts)
   );

   mrtu_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .in_kind            (req_tuser),
      .in_rx_data         (req_tdata[7:0]),
      .in_rx_last         (req_tlast),
      .in_table_select    (req_tdata[9:8]),
      .in_table_index     (req_tdata[15:10]),
      .in_table_word      (req_tdata[31:16]),
      .csr_we             (csr_valid && csr_ready),
      .csr_idx            (csr_index),
      .csr_wdata          (csr_data),
      .out_ready          (rsp_tready),
      .out_valid          (rsp_tvalid),
      .out_tx_byte        (o_tx_byte),
      .out_tx_last        (o_tx_last),
      .out_response_done  (o_done),
      .out_status         (o_status),
      .out_exception_code (o_exc),
      .out_error_total    (o_total),
      .out_error_slave    (o_slave),
      .out_error_function (o_func),
      .out_read_word      (o_read)
   );

   // result packing, lowest field first
   assign rsp_tdata = {5'd0, o_read, o_func, o_slave, o_total, o_exc, o_status, o_tx_byte};
   assign rsp_tlast = o_tx_last;
   assign rsp_tuser = o_done;

endmodule
`default_nettype wire
